// ===== hw/rtl/cwmm_pkg.sv =====
// shared types, constants and helpers for the checkerboard window minimum core
package cwmm_pkg;

  localparam int WIN     = 8;
  localparam int HIST_W  = WIN - 1;
  localparam int VCNT_W  = 4;
  localparam int SUM_W   = 7;
  localparam int SCORE_W = 6;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 1;
  localparam int TDATA_W = 8;

  localparam logic [IDX_W-1:0]   CFG_IMAGE_ROWS = 1'b0;
  localparam logic [IDX_W-1:0]   CFG_IMAGE_COLS = 1'b1;
  localparam logic [CFG_W-1:0]   SIZE_RESET     = 11'd8;
  localparam logic [SUM_W-1:0]   WIN_AREA       = SUM_W'(WIN * WIN);
  localparam logic [SCORE_W-1:0] BEST_INIT      = SCORE_W'((WIN * WIN) / 2);

  typedef struct packed {
    logic mis;
    logic win_ok;
    logic frame_end;
  } cwmm_item_t;

  function automatic logic [VCNT_W-1:0] hist_ones(input logic [HIST_W-1:0] v);
    logic [VCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < HIST_W; i++) begin
      n = n + VCNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/checkerboard_window_min_mismatch_core.sv =====
// top level: least checkerboard mismatch over all 8x8 windows of a binary frame
// throughput: one pixel item per cycle unless stalled, one history read and write per cycle
// the last pixel passes the input item register, then the result register raises out_tvalid
// a held result stalls input only once the next frame-end item waits in the input register
// reset: synchronous active-low; then a sweep over all MAX_COLS entries zeroes the column history
// with in_tready low, configuration writes still taken; frame sizes return to 8x8
module checkerboard_window_min_mismatch_core #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cwmm_pkg::TDATA_W-1:0]  in_tdata,   // [0] pixel_black
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cwmm_pkg::TDATA_W-1:0]  out_tdata,  // [5:0] min_repaints
  output logic                          out_tuser,  // [0] window_found
  input  logic                          cfg_we,
  input  logic [cwmm_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [cwmm_pkg::CFG_W-1:0]    cfg_wdata
);
  import cwmm_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  logic               accept, pipe_move, b_go, retire, clearing;
  logic               b_valid;
  cwmm_item_t         b_item;
  logic [CW-1:0]      rd_col, b_col;
  logic [VCNT_W-1:0]  vcount;
  logic [SCORE_W-1:0] out_min;

  assign b_go      = !b_item.frame_end || !out_tvalid || out_tready;
  assign pipe_move = !b_valid || b_go;
  assign retire    = b_valid && b_go;
  assign in_tready = !clearing && pipe_move;
  assign accept    = in_tvalid && in_tready;

  cwmm_position #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .pixel    (in_tdata[0]),
    .pipe_move(pipe_move),
    .rd_col   (rd_col),
    .b_valid  (b_valid),
    .b_item   (b_item),
    .b_col    (b_col)
  );

  cwmm_column_hist #(
    .MAX_COLS(MAX_COLS)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_col  (rd_col),
    .wr_en   (retire),
    .wr_col  (b_col),
    .mis     (b_item.mis),
    .vcount  (vcount),
    .clearing(clearing)
  );

  cwmm_window_score u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .retire   (retire),
    .item     (b_item),
    .vcount   (vcount),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_min  (out_min),
    .out_found(out_tuser)
  );

  assign out_tdata = {(TDATA_W - SCORE_W)'(0), out_min};

endmodule

// ===== hw/rtl/cwmm_position.sv =====
// configuration registers, raster position counters and the input item register
module cwmm_position #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cwmm_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [cwmm_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          accept,
  input  logic                          pixel,
  input  logic                          pipe_move,
  output logic [CW-1:0]                 rd_col,
  output logic                          b_valid,
  output cwmm_pkg::cwmm_item_t          b_item,
  output logic [CW-1:0]                 b_col
);
  import cwmm_pkg::*;

  logic [CFG_W-1:0] rows_r, cols_r;
  logic [CFG_W-1:0] rows_cl, cols_cl;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             row_last, col_last;
  logic             b_valid_r;
  cwmm_item_t       b_item_r, item_nxt;
  logic [CW-1:0]    b_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_RESET;
      cols_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IMAGE_ROWS: rows_r <= cfg_wdata;
        CFG_IMAGE_COLS: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize reads as the maximum
  always_comb begin
    if (rows_r == '0) rows_cl = CFG_W'(1);
    else if (32'(rows_r) > MAX_ROWS) rows_cl = CFG_W'(MAX_ROWS);
    else rows_cl = rows_r;
    if (cols_r == '0) cols_cl = CFG_W'(1);
    else if (32'(cols_r) > MAX_COLS) cols_cl = CFG_W'(MAX_COLS);
    else cols_cl = cols_r;
  end

  assign row_last = 32'(row_r) >= (32'(rows_cl) - 32'd1);
  assign col_last = 32'(col_r) >= (32'(cols_cl) - 32'd1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    item_nxt.mis       = pixel ^ row_r[0] ^ col_r[0];
    item_nxt.win_ok    = (32'(row_r) >= WIN - 1) && (32'(col_r) >= WIN - 1);
    item_nxt.frame_end = col_last && row_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (pipe_move) b_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item_r <= item_nxt;
      b_col_r  <= col_r;
    end
  end

  assign rd_col  = col_r;
  assign b_valid = b_valid_r;
  assign b_item  = b_item_r;
  assign b_col   = b_col_r;

endmodule

// ===== hw/rtl/cwmm_column_hist.sv =====
// per-column mismatch history memory with clearing sweep and write bypass
module cwmm_column_hist #(
  parameter int MAX_COLS = 1024,
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [CW-1:0]                 rd_col,
  input  logic                          wr_en,
  input  logic [CW-1:0]                 wr_col,
  input  logic                          mis,
  output logic [cwmm_pkg::VCNT_W-1:0]   vcount,
  output logic                          clearing
);
  import cwmm_pkg::*;

  logic [HIST_W-1:0] mem [MAX_COLS];
  logic [HIST_W-1:0] rd_data_r, byp_data_r;
  logic              byp_sel_r;
  logic [HIST_W-1:0] hist_cur, hist_new;
  logic              clear_r;
  logic [CW-1:0]     clr_idx_r;

  assign hist_cur = byp_sel_r ? byp_data_r : rd_data_r;
  assign hist_new = {hist_cur[HIST_W-2:0], mis};
  assign vcount   = hist_ones(hist_cur) + VCNT_W'(mis);

  always_ff @(posedge clk) begin
    if (clear_r) mem[clr_idx_r] <= '0;
    else if (wr_en) mem[wr_col] <= hist_new;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_col];
  end

  // same column written by the item ahead
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_sel_r  <= wr_en && (wr_col == rd_col);
      byp_data_r <= hist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_idx_r <= '0;
    end else if (clear_r) begin
      clr_idx_r <= clr_idx_r + CW'(1);
      if (clr_idx_r == CW'(MAX_COLS - 1)) clear_r <= 1'b0;
    end
  end

  assign clearing = clear_r;

endmodule

// ===== hw/rtl/cwmm_window_score.sv =====
// horizontal window sum, best score tracking and result register
module cwmm_window_score (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           retire,
  input  cwmm_pkg::cwmm_item_t           item,
  input  logic [cwmm_pkg::VCNT_W-1:0]    vcount,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [cwmm_pkg::SCORE_W-1:0]   out_min,
  output logic                           out_found
);
  import cwmm_pkg::*;

  logic [VCNT_W-1:0]  cw_r [WIN];
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   other;
  logic [SCORE_W-1:0] score, best_upd;
  logic [SCORE_W-1:0] best_r;
  logic               any_r, any_upd;
  logic               out_valid_r, out_found_r;
  logic [SCORE_W-1:0] out_min_r;

  always_comb begin
    sum_nxt  = sum_r - SUM_W'(cw_r[0]) + SUM_W'(vcount);
    other    = WIN_AREA - sum_nxt;
    score    = (sum_nxt < other) ? sum_nxt[SCORE_W-1:0] : other[SCORE_W-1:0];
    best_upd = (item.win_ok && (score < best_r)) ? score : best_r;
    any_upd  = any_r | item.win_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) cw_r[i] <= '0;
      sum_r  <= '0;
      best_r <= BEST_INIT;
      any_r  <= 1'b0;
    end else if (retire) begin
      for (int i = 0; i < WIN - 1; i++) cw_r[i] <= cw_r[i+1];
      cw_r[WIN-1] <= vcount;
      sum_r       <= sum_nxt;
      if (item.frame_end) begin
        best_r <= BEST_INIT;
        any_r  <= 1'b0;
      end else begin
        best_r <= best_upd;
        any_r  <= any_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire && item.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && item.frame_end) begin
      out_min_r   <= any_upd ? best_upd : '0;
      out_found_r <= any_upd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_min   = out_min_r;
  assign out_found = out_found_r;

endmodule

// ===== hw/rtl/cwmm_checker.sv =====
// port-level assertions for the checkerboard window minimum core, with bind
module cwmm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [cwmm_pkg::TDATA_W-1:0]  out_tdata,
  input logic                          out_tuser
);
  import cwmm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[SCORE_W-1:0] <= BEST_INIT) && (out_tdata[TDATA_W-1:SCORE_W] == '0))
    else $error("min_repaints out of range");

  a_no_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[SCORE_W-1:0] == '0)
    else $error("nonzero count without a window");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("item taken during history sweep");

endmodule

bind checkerboard_window_min_mismatch_core cwmm_checker u_cwmm_checker (.*);

// ===== bench/cwmm_frame_checker.sv =====
// frame checker: predicts the least checkerboard mismatch of each frame and compares result items
module cwmm_frame_checker #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [cwmm_pkg::TDATA_W-1:0] in_tdata,   // [0] pixel_black
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [cwmm_pkg::TDATA_W-1:0] out_tdata,  // [5:0] min_repaints
  input  logic                         out_tuser,  // [0] window_found
  input  logic                         cfg_we,
  input  logic [cwmm_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [cwmm_pkg::CFG_W-1:0]   cfg_wdata,
  output int                           fail_count,
  output int                           pending_results,
  output int                           pixel_count,
  output int                           frame_count,
  output int                           window_frame_count
);
  import cwmm_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0] min_repaints;
    logic               window_found;
  } frame_result_t;

  logic [CFG_W-1:0]   rows_reg;
  logic [CFG_W-1:0]   cols_reg;
  logic [HIST_W-1:0]  col_hist [MAX_COLS];
  logic [VCNT_W-1:0]  col_counts [WIN];
  logic [SUM_W-1:0]   win_sum;
  logic [9:0]         row_pos;
  logic [9:0]         col_pos;
  logic [SCORE_W-1:0] best_score;
  logic               window_seen;
  frame_result_t      expected_minima [$];

  // zero reads as one, oversize reads as the maximum
  function automatic int effective_size(input logic [CFG_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic restart_frame();
    row_pos     = '0;
    col_pos     = '0;
    best_score  = BEST_INIT;
    window_seen = 1'b0;
  endtask

  task automatic take_pixel(input logic pix);
    int                rows;
    int                cols;
    int                s;
    int                score;
    logic              mis;
    logic [HIST_W-1:0] hist;
    logic [VCNT_W-1:0] vcount;
    frame_result_t     res;
    rows = effective_size(rows_reg, MAX_ROWS);
    cols = effective_size(cols_reg, MAX_COLS);
    mis  = pix ^ row_pos[0] ^ col_pos[0];
    hist = (int'(col_pos) < MAX_COLS) ? col_hist[col_pos] : '0;
    vcount = VCNT_W'($countones(hist)) + VCNT_W'(mis);
    if (int'(col_pos) < MAX_COLS) col_hist[col_pos] = {hist[HIST_W-2:0], mis};
    win_sum = win_sum - SUM_W'(col_counts[0]) + SUM_W'(vcount);
    for (int k = 0; k < WIN - 1; k++) col_counts[k] = col_counts[k+1];
    col_counts[WIN-1] = vcount;
    if (int'(row_pos) >= WIN - 1 && int'(col_pos) >= WIN - 1) begin
      // the opposite phase mismatches the rest of the window
      s     = int'(win_sum);
      score = (s < WIN * WIN - s) ? s : WIN * WIN - s;
      if (score < int'(best_score)) best_score = SCORE_W'(score);
      window_seen = 1'b1;
    end
    if (int'(col_pos) >= cols - 1) begin
      col_pos = '0;
      if (int'(row_pos) >= rows - 1) begin
        res.window_found = window_seen;
        res.min_repaints = window_seen ? best_score : '0;
        expected_minima.push_back(res);
        restart_frame();
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      rows_reg = SIZE_RESET;
      cols_reg = SIZE_RESET;
      for (int i = 0; i < MAX_COLS; i++) col_hist[i] = '0;
      for (int k = 0; k < WIN; k++) col_counts[k] = '0;
      win_sum = '0;
      restart_frame();
      expected_minima.delete();
      fail_count         = 0;
      pixel_count        = 0;
      frame_count        = 0;
      window_frame_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_IMAGE_ROWS: rows_reg = cfg_wdata;
          CFG_IMAGE_COLS: cols_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        take_pixel(in_tdata[0]);
        pixel_count++;
      end
      if (out_tvalid && out_tready) begin
        frame_count++;
        if (expected_minima.size() == 0) begin
          fail_count++;
          $display("%0t: result item with none expected: min_repaints %0d window_found %0b",
                   $time, out_tdata[SCORE_W-1:0], out_tuser);
        end else begin
          want = expected_minima.pop_front();
          if (want.window_found) window_frame_count++;
          if (out_tdata[SCORE_W-1:0] !== want.min_repaints) begin
            fail_count++;
            $display("%0t: min_repaints expected %0d, got %0d",
                     $time, want.min_repaints, out_tdata[SCORE_W-1:0]);
          end
          if (out_tuser !== want.window_found) begin
            fail_count++;
            $display("%0t: window_found expected %0b, got %0b",
                     $time, want.window_found, out_tuser);
          end
        end
      end
    end
    pending_results = expected_minima.size();
  end

endmodule

// ===== bench/tb_checkerboard_window_min_mismatch_core.sv =====
// testbench top: pixel stimulus, frame size changes, output stalls and the verdict
module tb_checkerboard_window_min_mismatch_core;
  import cwmm_pkg::*;

  localparam int MAX_ROWS       = 1024;
  localparam int MAX_COLS       = 1024;
  localparam int ITEM_TARGET    = 1450;
  localparam int RESULT_TARGET  = 48;
  localparam int IDLE_PCT       = 13;
  localparam int HOLD_OFF       = 300;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_GAP      = 6;
  localparam int KIND_PRESSURE  = 10;
  localparam int KIND_WIDE      = 11;

  typedef enum logic [1:0] {PIX_RANDOM, PIX_CHECKER, PIX_SOLID} pixel_style_e;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;   // [0] pixel_black
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;  // [5:0] min_repaints
  logic               out_tuser;  // [0] window_found
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]   cfg_wdata;

  int fail_count;
  int pending_results;
  int pixel_count;
  int frame_count;
  int window_frame_count;
  int tx_count;
  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  bit hold_req;

  checkerboard_window_min_mismatch_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  cwmm_frame_checker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) i_frame_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .out_tuser          (out_tuser),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .pixel_count        (pixel_count),
    .frame_count        (frame_count),
    .window_frame_count (window_frame_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int frame_extent(input logic [CFG_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic logic [CFG_W-1:0] pick_edge_size();
    case ($urandom_range(3))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(WIN - 1);
      default: return CFG_W'(WIN);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic push_pixel(input logic pix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(pix);
    do @(posedge clk); while (!in_tready);
    tx_count++;
    @(negedge clk);
  endtask

  task automatic send_pixels(input int count, input int cols_eff, input pixel_style_e style,
                             input logic phase_bit, input int flip_pct);
    int   rr;
    int   cc;
    logic pix;
    for (int i = 0; i < count; i++) begin
      rr = i / cols_eff;
      cc = i % cols_eff;
      case (style)
        PIX_RANDOM:  pix = 1'($urandom_range(1));
        PIX_CHECKER: pix = phase_bit ^ rr[0] ^ cc[0];
        default:     pix = phase_bit;
      endcase
      if ($urandom_range(99) < flip_pct) pix = ~pix;
      push_pixel(pix);
    end
  endtask

  // lets the block settle so that a size change lands between items
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_frame_size(input logic [CFG_W-1:0] rows_v, input logic [CFG_W-1:0] cols_v);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IMAGE_ROWS;
    cfg_wdata <= rows_v;
    @(negedge clk);
    cfg_idx   <= CFG_IMAGE_COLS;
    cfg_wdata <= cols_v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles with no item taken, %0d results outstanding",
                 quiet, pending_results);
        $display("tb_checkerboard_window_min_mismatch_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int               kind;
    int               phase_no;
    int               n_frames;
    int               n_pix;
    int               flip_pct;
    logic [CFG_W-1:0] rows_v;
    logic [CFG_W-1:0] cols_v;
    pixel_style_e     style;
    logic             phase_bit;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_IMAGE_ROWS;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    tx_count  = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // zero sizes read as a single pixel, so every pixel closes a frame without a window
    write_frame_size('0, '0);
    push_pixel(1'b1);
    push_pixel(1'b0);
    drain();
    write_frame_size(CFG_W'(1), CFG_W'(3));
    push_pixel(1'b1);
    push_pixel(1'b0);
    push_pixel(1'b1);
    drain();
    // size changes in the middle of a frame, through the largest register values
    write_frame_size(CFG_W'(2), CFG_W'(5));
    push_pixel(1'b1);
    push_pixel(1'b1);
    push_pixel(1'b0);
    drain();
    write_frame_size('1, '1);
    push_pixel(1'b0);
    push_pixel(1'b1);
    drain();
    write_frame_size(CFG_W'(2), CFG_W'(1));
    push_pixel(1'b1);
    push_pixel(1'b0);

    phase_no = 0;
    while (tx_count < ITEM_TARGET || frame_count < RESULT_TARGET) begin
      drain();
      tx_idle_pct = (phase_no >= 1 && phase_no < 3) ? 0 : IDLE_PCT;
      rx_idle_pct = tx_idle_pct;
      style     = pixel_style_e'($urandom_range(2));
      phase_bit = 1'($urandom_range(1));
      flip_pct  = $urandom_range(8);
      n_frames  = $urandom_range(1, 3);
      n_pix     = -1;
      kind      = $urandom_range(8);
      if (phase_no == 2) kind = KIND_PRESSURE;
      if (phase_no == 1) kind = KIND_WIDE;
      case (kind)
        0, 1, 2, 3: begin
          rows_v = CFG_W'($urandom_range(WIN, WIN + 4));
          cols_v = CFG_W'($urandom_range(WIN, 2 * WIN));
        end
        4, 5: begin
          if ($urandom_range(1)) begin
            rows_v = CFG_W'($urandom_range(1, WIN - 1));
            cols_v = CFG_W'($urandom_range(1, 12));
          end else begin
            rows_v = CFG_W'($urandom_range(1, 10));
            cols_v = CFG_W'($urandom_range(1, WIN - 1));
          end
          n_frames = $urandom_range(1, 5);
        end
        6: begin
          rows_v = pick_edge_size();
          cols_v = pick_edge_size();
        end
        7, 8: begin
          // tall frame left unfinished, the next size change cuts it short
          rows_v = $urandom_range(1) ? '1 : CFG_W'($urandom_range(WIN + 1, 2047));
          cols_v = CFG_W'($urandom_range(1, WIN + 1));
          n_pix  = $urandom_range(5, 60);
        end
        KIND_PRESSURE: begin
          rows_v      = CFG_W'(1);
          cols_v      = CFG_W'(1);
          n_frames    = 40;
          tx_idle_pct = 0;
        end
        default: begin
          // one full row at the column limit
          rows_v   = '0;
          cols_v   = '1;
          n_frames = 1;
        end
      endcase
      write_frame_size(rows_v, cols_v);
      if (n_pix < 0)
        n_pix = n_frames * frame_extent(rows_v, MAX_ROWS) * frame_extent(cols_v, MAX_COLS);
      if (kind == KIND_PRESSURE) hold_req = 1'b1;
      send_pixels(n_pix, frame_extent(cols_v, MAX_COLS), style, phase_bit, flip_pct);
      phase_no++;
    end

    drain();
    $display("%0d pixel items in %0d phases, %0d frame results, %0d of them with a fitting window",
             pixel_count, phase_no, frame_count, window_frame_count);
    $display("sizes from 1x1 to a full %0d-pixel row, mid-frame size changes, %0d-cycle hold-off",
             MAX_COLS, HOLD_OFF);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_checkerboard_window_min_mismatch_core: done, clean");
    end else begin
      $display("tb_checkerboard_window_min_mismatch_core: done, errors");
    end
    $finish;
  end

endmodule
